// File: rtl/mi4_pkg.sv
// Package: shared types and constants for the 4x4 matrix inverse block.
package mi4_pkg;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_COF_RD,
        ST_COF_MUL,
        ST_COF_END,
        ST_DET_RD,
        ST_DET,
        ST_DIV,
        ST_DIV_WAIT,
        ST_EMIT_RD,
        ST_EMIT_MUL,
        ST_EMIT_OUT,
        ST_SING_OUT
    } mi4_state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PROD,
        OP_COF_TERM,
        OP_COF_STORE,
        OP_DET_TERM,
        OP_DIV_START,
        OP_EMIT
    } mi4_op_t;

    // Multiplier operand select.
    typedef enum logic [1:0] {
        SEL_PAIR,
        SEL_TRIPLE,
        SEL_DET,
        SEL_EMIT
    } mi4_sel_t;

    typedef struct packed {
        mi4_op_t    op;
        mi4_sel_t   sel;
        logic [3:0] cof_idx;
        logic [2:0] term;
        logic [1:0] det_col;
        logic       clear_acc;
    } mi4_cmd_t;

    typedef struct packed {
        logic busy;
        logic div_done;
        logic det_zero;
    } mi4_status_t;

    function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        begin
            s = {a[63], a} + {b[63], b};
            if (s[64] != s[63])
                add_sat = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            else
                add_sat = s[63:0];
        end
    endfunction

    // Minor row/col selection: index k (0..2) skipping s.
    function automatic logic [1:0] skip_sel(input logic [1:0] s, input logic [1:0] k);
        begin
            skip_sel = (k >= s) ? k + 2'd1 : k;
        end
    endfunction

endpackage

// File: rtl/mi4_if.sv
// Interfaces: valid/ready channels for input elements and results.
interface mi4_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] element_value;
    logic [1:0]         element_row;
    logic [1:0]         element_col;
    logic               start_compute;
    modport source (output valid, element_value, element_row, element_col, start_compute,
                    input ready);
    modport sink   (input valid, element_value, element_row, element_col, start_compute,
                    output ready);
endinterface

interface mi4_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic [1:0]         result_row;
    logic [1:0]         result_col;
    logic               singular;
    logic               saturated;
    logic               last_result;
    modport source (output valid, result_value, result_row, result_col, singular, saturated,
                    last_result, input ready);
    modport sink   (input valid, result_value, result_row, result_col, singular, saturated,
                    last_result, output ready);
endinterface

// File: rtl/mi4_mul.sv
// Multi-cycle signed 64x64 multiply, shift toward zero, saturate to 64 bits.
module mi4_mul
    import mi4_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    input  logic [5:0]         sh,
    output logic               done,
    output logic signed [63:0] result,
    output logic               sat
);
    logic [63:0]  ua_reg, ub_reg, ua_next, ub_next;
    logic         neg_reg, neg_next;
    logic [127:0] acc_reg, acc_next;
    logic [2:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [5:0]   sh_reg, sh_next;
    logic [63:0]  pp;
    logic [31:0]  pa, pb;
    logic [127:0] shifted;
    logic [63:0]  qlo;
    logic         qhi_nz;

    assign pa = cnt_reg[1] ? ua_reg[63:32] : ua_reg[31:0];
    assign pb = cnt_reg[0] ? ub_reg[63:32] : ub_reg[31:0];
    assign pp = pa * pb;
    assign shifted = acc_reg >> sh_reg;
    assign qlo = shifted[63:0];
    assign qhi_nz = |shifted[127:64];

    always_comb
    begin
        ua_next = ua_reg; ub_next = ub_reg; neg_next = neg_reg; acc_next = acc_reg;
        cnt_next = cnt_reg; busy_next = busy_reg; done_next = 1'b0; sh_next = sh_reg;
        if (start)
        begin
            ua_next = a[63] ? 64'd0 - a : a;
            ub_next = b[63] ? 64'd0 - b : b;
            neg_next = a[63] != b[63];
            acc_next = '0;
            cnt_next = '0;
            busy_next = 1'b1;
            sh_next = sh;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + ({64'd0, pp} << ({5'd0, cnt_reg[1]} * 32 + {5'd0, cnt_reg[0]} * 32));
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd3)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ua_reg <= ua_next; ub_reg <= ub_next; neg_reg <= neg_next;
        acc_reg <= acc_next; sh_reg <= sh_next;
    end

    assign done = done_reg;

    always_comb
    begin
        sat = 1'b0;
        if (qhi_nz || qlo > {1'b1, 63'd0} || (qlo == {1'b1, 63'd0} && !neg_reg))
        begin
            sat = 1'b1;
            result = neg_reg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        else if (qlo == {1'b1, 63'd0})
            result = {1'b1, 63'd0};
        else
            result = neg_reg ? $signed(64'd0 - qlo) : $signed(qlo);
    end
endmodule

// File: rtl/mi4_div.sv
// Radix-2 restoring divider: 2^62 / signed divisor, truncated toward zero.
module mi4_div
    import mi4_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] divisor,
    output logic               done,
    output logic signed [63:0] quotient
);
    logic [63:0] d_reg, d_next, q_reg, q_next, r_reg, r_next;
    logic        neg_reg, neg_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next, done_reg, done_next;
    logic [64:0] r_sh;
    logic        bit_in;

    assign bit_in = (cnt_reg == 7'd1);
    assign r_sh = {r_reg, bit_in};

    always_comb
    begin
        d_next = d_reg; q_next = q_reg; r_next = r_reg; neg_next = neg_reg;
        cnt_next = cnt_reg; busy_next = busy_reg; done_next = 1'b0;
        if (start)
        begin
            d_next = divisor[63] ? 64'd0 - divisor : divisor;
            neg_next = divisor[63];
            q_next = '0; r_next = '0; cnt_next = '0; busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (r_sh >= {1'b0, d_reg})
            begin
                r_next = 64'(r_sh - {1'b0, d_reg});
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_next = r_sh[63:0];
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0; done_reg <= 1'b0; cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next; done_reg <= done_next; cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg <= d_next; q_reg <= q_next; r_reg <= r_next; neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quotient = neg_reg ? $signed(64'd0 - q_reg) : $signed(q_reg);
endmodule

// File: rtl/mi4_ctrl.sv
// Controller: sequences cofactors, determinant, division and result emission.
module mi4_ctrl
    import mi4_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_fire,
    input  logic        in_start,
    input  logic        mul_done,
    input  logic        out_fire,
    input  mi4_status_t status,
    output mi4_cmd_t    cmd,
    output logic        in_ready,
    output logic        out_valid,
    output logic        mul_start
);
    mi4_state_t state_reg, state_next;
    logic [3:0] idx_reg, idx_next;
    logic [2:0] term_reg, term_next;
    logic [1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD; idx_reg <= '0; term_reg <= '0; step_reg <= '0;
        end
        else
        begin
            state_reg <= state_next; idx_reg <= idx_next;
            term_reg <= term_next; step_reg <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg; idx_next = idx_reg; term_next = term_reg; step_next = step_reg;
        cmd = '{op: OP_NONE, sel: SEL_PAIR, cof_idx: idx_reg, term: term_reg,
                det_col: idx_reg[1:0], clear_acc: 1'b0};
        in_ready = 1'b0; out_valid = 1'b0; mul_start = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_fire && in_start)
                begin
                    state_next = ST_COF_RD; idx_next = '0; term_next = '0; step_next = '0;
                    cmd.clear_acc = 1'b1;
                end
            end
            ST_COF_RD:
            begin
                mul_start = 1'b1;
                cmd.sel = (step_reg == 2'd1) ? SEL_TRIPLE : SEL_PAIR;
                state_next = ST_COF_MUL;
            end
            ST_COF_MUL:
            begin
                if (mul_done)
                begin
                    if (step_reg == 2'd0)
                    begin
                        step_next = 2'd1;
                        cmd.op = OP_PROD;
                        state_next = ST_COF_RD;
                    end
                    else
                    begin
                        cmd.op = OP_COF_TERM;
                        step_next = 2'd0;
                        if (term_reg == 3'd5)
                            state_next = ST_COF_END;
                        else
                        begin
                            term_next = term_reg + 3'd1;
                            state_next = ST_COF_RD;
                        end
                    end
                end
            end
            ST_COF_END:
            begin
                cmd.op = OP_COF_STORE;
                term_next = '0;
                if (idx_reg == 4'd15)
                begin
                    idx_next = '0; state_next = ST_DET_RD;
                end
                else
                begin
                    idx_next = idx_reg + 4'd1; state_next = ST_COF_RD;
                end
            end
            ST_DET_RD:
            begin
                mul_start = 1'b1;
                cmd.sel = SEL_DET;
                state_next = ST_DET;
            end
            ST_DET:
            begin
                if (mul_done)
                begin
                    cmd.op = OP_DET_TERM;
                    if (idx_reg == 4'd3)
                    begin
                        idx_next = '0; state_next = ST_DIV;
                    end
                    else
                    begin
                        idx_next = idx_reg + 4'd1; state_next = ST_DET_RD;
                    end
                end
            end
            ST_DIV:
            begin
                if (status.det_zero)
                    state_next = ST_SING_OUT;
                else
                begin
                    cmd.op = OP_DIV_START;
                    state_next = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT:
            begin
                if (status.div_done)
                    state_next = ST_EMIT_RD;
            end
            ST_EMIT_RD:
            begin
                mul_start = 1'b1;
                cmd.sel = SEL_EMIT;
                state_next = ST_EMIT_MUL;
            end
            ST_EMIT_MUL:
            begin
                if (mul_done)
                begin
                    cmd.op = OP_EMIT;
                    state_next = ST_EMIT_OUT;
                end
            end
            ST_EMIT_OUT:
            begin
                out_valid = 1'b1;
                if (out_fire)
                begin
                    if (idx_reg == 4'd15)
                    begin
                        idx_next = '0; state_next = ST_LOAD;
                    end
                    else
                    begin
                        idx_next = idx_reg + 4'd1; state_next = ST_EMIT_RD;
                    end
                end
            end
            ST_SING_OUT:
            begin
                out_valid = 1'b1;
                if (out_fire)
                    state_next = ST_LOAD;
            end
            default:
                state_next = ST_LOAD;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n) in_ready |-> !out_valid)
        else $error("input and output open together");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT_OUT && out_valid && !out_fire) |=> state_reg == ST_EMIT_OUT)
        else $error("result dropped under stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SING_OUT && out_fire) |=> state_reg == ST_LOAD)
        else $error("singular result not final");
endmodule

// File: rtl/mi4_dp.sv
// Datapath: element store, shared multiplier, cofactors, determinant, divider.
module mi4_dp
    import mi4_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [3:0]         wr_addr,
    input  logic [31:0]        wr_data,
    input  mi4_cmd_t           cmd,
    input  logic               mul_start,
    output logic               mul_done,
    output mi4_status_t        status,
    output logic signed [31:0] result_value,
    output logic [1:0]         result_row,
    output logic [1:0]         result_col,
    output logic               saturated
);
    localparam int RECIP_BITS = 62 - FRAC_BITS;
    localparam logic signed [63:0] WMAX = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] WMIN = -WMAX - 64'sd1;

    logic signed [WORD_BITS-1:0] elem_reg [16];
    logic signed [63:0] cof_reg [16];
    logic signed [63:0] acc_reg, det_reg, recip_reg, prod_reg;
    logic [1:0] sr, sc, r0, r1, r2, c0, c1, c2;
    logic signed [63:0] opa, opb, mres, neg_m, cof_val;
    logic [5:0] sh;
    logic msat, div_done, div_start;
    logic signed [63:0] quot;
    logic [1:0] ti, tj, tk;
    logic div_busy_reg, div_done_reg;
    logic signed [31:0] res_reg;
    logic res_sat_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            elem_reg[wr_addr] <= wr_data[WORD_BITS-1:0];
    end

    // adjugate entry (i,j) = cofactor of element (j,i)
    assign sr = cmd.cof_idx[1:0];
    assign sc = cmd.cof_idx[3:2];
    assign r0 = skip_sel(sr, 2'd0); assign r1 = skip_sel(sr, 2'd1); assign r2 = skip_sel(sr, 2'd2);
    assign c0 = skip_sel(sc, 2'd0); assign c1 = skip_sel(sc, 2'd1); assign c2 = skip_sel(sc, 2'd2);

    always_comb
    begin
        case (cmd.term)
            3'd0: begin ti = c0; tj = c1; tk = c2; end
            3'd1: begin ti = c1; tj = c2; tk = c0; end
            3'd2: begin ti = c2; tj = c0; tk = c1; end
            3'd3: begin ti = c0; tj = c2; tk = c1; end
            3'd4: begin ti = c1; tj = c0; tk = c2; end
            default: begin ti = c2; tj = c1; tk = c0; end
        endcase
    end

    always_comb
    begin
        opa = 64'(elem_reg[{r0, ti}]);
        opb = 64'(elem_reg[{r1, tj}]);
        sh = 6'(FRAC_BITS);
        case (cmd.sel)
            SEL_TRIPLE:
            begin
                opa = prod_reg;
                opb = 64'(elem_reg[{r2, tk}]);
            end
            SEL_DET:
            begin
                opa = 64'(elem_reg[{2'd0, cmd.det_col}]);
                opb = cof_reg[{cmd.det_col, 2'd0}];
            end
            SEL_EMIT:
            begin
                opa = cof_reg[cmd.cof_idx];
                opb = recip_reg;
                sh = 6'(RECIP_BITS);
            end
            default:
            begin
                opa = 64'(elem_reg[{r0, ti}]);
                opb = 64'(elem_reg[{r1, tj}]);
            end
        endcase
    end

    mi4_mul u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .a(opa), .b(opb), .sh(sh),
        .done(mul_done), .result(mres), .sat(msat)
    );

    assign div_start = (cmd.op == OP_DIV_START);

    mi4_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .divisor(det_reg),
        .done(div_done), .quotient(quot)
    );

    assign neg_m = (mres == {1'b1, 63'd0}) ? {1'b0, {63{1'b1}}} : -mres;
    assign cof_val = (sr[0] ^ sc[0]) ? ((acc_reg == {1'b1, 63'd0}) ? {1'b0, {63{1'b1}}}
                                                                   : -acc_reg) : acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0; div_done_reg <= 1'b0;
            det_reg <= '0; recip_reg <= '0;
            for (int i = 0; i < 16; i++)
                cof_reg[i] <= '0;
        end
        else
        begin
            if (cmd.op == OP_COF_STORE)
                cof_reg[cmd.cof_idx] <= cof_val;
            if (cmd.clear_acc)
            begin
                det_reg <= '0; div_done_reg <= 1'b0;
            end
            if (cmd.op == OP_DET_TERM)
                det_reg <= add_sat(det_reg, mres);
            if (div_start)
                div_busy_reg <= 1'b1;
            if (div_done)
            begin
                div_busy_reg <= 1'b0; div_done_reg <= 1'b1; recip_reg <= quot;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_PROD)
            prod_reg <= mres;
        if (cmd.clear_acc || cmd.op == OP_COF_STORE)
            acc_reg <= '0;
        else if (cmd.op == OP_COF_TERM)
            acc_reg <= add_sat(acc_reg, cmd.term >= 3'd3 ? neg_m : mres);
        if (cmd.op == OP_EMIT)
        begin
            if (mres > WMAX)
            begin
                res_reg <= WMAX[31:0]; res_sat_reg <= 1'b1;
            end
            else if (mres < WMIN)
            begin
                res_reg <= WMIN[31:0]; res_sat_reg <= 1'b1;
            end
            else
            begin
                res_reg <= mres[31:0]; res_sat_reg <= msat;
            end
        end
    end

    assign status.busy = div_busy_reg;
    assign status.div_done = div_done_reg;
    assign status.det_zero = (det_reg == 64'sd0);

    assign result_value = res_reg;
    assign result_row = cmd.cof_idx[3:2];
    assign result_col = cmd.cof_idx[1:0];
    assign saturated = res_sat_reg;

    assert property (@(posedge clk) disable iff (!rst_n) div_start |-> !div_busy_reg)
        else $error("divider restarted while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_PROD || cmd.op == OP_COF_TERM || cmd.op == OP_DET_TERM
         || cmd.op == OP_EMIT) |-> mul_done)
        else $error("product taken before multiplier done");
    assert property (@(posedge clk) disable iff (!rst_n) div_done |=> div_done_reg)
        else $error("reciprocal not captured");
endmodule

// File: rtl/matrix_inverse_4x4.sv
// Top level: 4x4 fixed-point matrix inverse by the adjugate method.
// Usage:
//   in channel: one transaction per matrix element (value, row, col). The
//   transaction with start_compute set stores its element and starts the
//   inversion; other transactions only load the element store.
//   out channel: sixteen row-major inverse elements, or one transaction with
//   singular set. last_result marks the final transaction of a matrix.
// Compute: 192 cofactor products on one shared multiplier, each cofactor
//   followed by a store, 4 determinant products, a 64-step divide, then
//   one product per result element; a singular matrix skips the divide and
//   the result products.
// Flow: the in channel takes loads back to back; the shared multiplier
//   sets the compute time. in.ready is low from start_compute until the
//   last result transaction is taken.
// Reset: asynchronous, active low; cofactors, determinant and reciprocal
//   clear, the element store is undefined until all sixteen are written.
// Stall: a result holds on the out channel until out.ready; compute waits.
module matrix_inverse_4x4
    import mi4_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
)
(
    input  logic clk,
    input  logic rst_n,
    mi4_in_if.sink    in_ch,
    mi4_out_if.source out_ch
);
    mi4_cmd_t    cmd;
    mi4_status_t status;
    logic in_fire, out_fire, mul_start, mul_done, out_valid, in_ready, sing;

    assign in_fire  = in_ch.valid && in_ready;
    assign out_fire = out_valid && out_ch.ready;
    assign in_ch.ready = in_ready;
    assign out_ch.valid = out_valid;

    mi4_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_start(in_ch.start_compute),
        .mul_done(mul_done), .out_fire(out_fire), .status(status), .cmd(cmd),
        .in_ready(in_ready), .out_valid(out_valid), .mul_start(mul_start)
    );

    logic signed [31:0] rv;
    logic [1:0] rr, rc;
    logic rs;

    mi4_dp #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .wr_en(in_fire),
        .wr_addr({in_ch.element_row, in_ch.element_col}), .wr_data(in_ch.element_value),
        .cmd(cmd), .mul_start(mul_start), .mul_done(mul_done), .status(status),
        .result_value(rv), .result_row(rr), .result_col(rc), .saturated(rs)
    );

    assign sing = status.det_zero && !status.busy && !status.div_done;
    assign out_ch.singular     = sing;
    assign out_ch.result_value = sing ? 32'sd0 : rv;
    assign out_ch.result_row   = sing ? 2'd0 : rr;
    assign out_ch.result_col   = sing ? 2'd0 : rc;
    assign out_ch.saturated    = sing ? 1'b0 : rs;
    assign out_ch.last_result  = sing || (rr == 2'd3 && rc == 2'd3);
endmodule
